// ===== rtl/t2s_pkg.sv =====
// Shared constants and the character-to-segment table of the
// text-to-segment frame sequencer. No dependencies.
package t2s_pkg;

  localparam int unsigned CharW            = 8;
  localparam int unsigned AddrW            = 4;
  localparam int unsigned DataW            = 8;
  localparam int unsigned CharFields       = 5;
  localparam int unsigned NumDigitsDefault = 5;

  localparam logic [AddrW-1:0] DecodeModeReg = 4'h9;
  localparam logic [AddrW-1:0] FirstDigitReg = 4'h1;
  localparam logic [DataW-1:0] BlankGlyph    = 8'h00;
  localparam logic [DataW-1:0] DecodeModeOff = 8'h00;
  localparam logic [CharW-1:0] EndOfMessage  = 8'h00;

  // Segment pattern of one character; anything not in the table is blank.
  function automatic logic [DataW-1:0] glyph_of(input logic [CharW-1:0] c);
    logic [DataW-1:0] g;
    case (c)
      "H":     g = 8'h37;
      "I":     g = 8'h30;
      "C":     g = 8'h4e;
      "N":     g = 8'h15;
      "D":     g = 8'h3d;
      "S":     g = 8'h5b;
      "L":     g = 8'h0e;
      "P":     g = 8'h67;
      "U":     g = 8'h1c;
      "A":     g = 8'h77;
      "F":     g = 8'h47;
      "Y":     g = 8'h3b;
      "E":     g = 8'h4f;
      "-":     g = 8'h01;
      "R":     g = 8'h05;
      "T":     g = 8'h0f;
      "O":     g = 8'h7e;
      "V":     g = 8'h3e;
      "0":     g = 8'h7e;
      "1":     g = 8'h30;
      "2":     g = 8'h6d;
      "3":     g = 8'h79;
      "4":     g = 8'h33;
      "5":     g = 8'h5b;
      "6":     g = 8'h5f;
      "7":     g = 8'h70;
      "8":     g = 8'h7f;
      "9":     g = 8'h7b;
      default: g = BlankGlyph;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/t2s_char_if.sv =====
// Valid/ready channel that carries one message of five character codes.
// Depends on t2s_pkg for the field width.
interface t2s_char_if import t2s_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_0;
  logic [CharW-1:0] char_1;
  logic [CharW-1:0] char_2;
  logic [CharW-1:0] char_3;
  logic [CharW-1:0] char_4;

  modport source (output valid, char_0, char_1, char_2, char_3, char_4, input ready);
  modport sink   (input valid, char_0, char_1, char_2, char_3, char_4, output ready);
endinterface

// ===== rtl/t2s_frame_if.sv =====
// Valid/ready channel that carries one display-driver register frame.
// Depends on t2s_pkg for the field widths.
interface t2s_frame_if import t2s_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] reg_address;
  logic [DataW-1:0] reg_data;
  logic             last_frame;

  modport source (output valid, reg_address, reg_data, last_frame, input ready);
  modport sink   (input valid, reg_address, reg_data, last_frame, output ready);
endinterface

// ===== rtl/t2s_lane.sv =====
// One decode lane: segment pattern and end-of-message flag of one character.
// Depends on t2s_pkg for the glyph table.
module t2s_lane import t2s_pkg::*; (
  input  logic [CharW-1:0] char_i,
  output logic [DataW-1:0] glyph_o,
  output logic             is_end_o
);

  assign glyph_o  = glyph_of(char_i);
  assign is_end_o = (char_i == EndOfMessage);

endmodule

// ===== rtl/t2s_merge.sv =====
// Merging stage: applies the terminator across the lane results and holds
// the message's digit patterns in a register. Depends on t2s_pkg.
module t2s_merge import t2s_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NumDigitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] glyph_i  [NUM_DIGITS],
  input  logic             is_end_i [NUM_DIGITS],
  output logic             valid_o,
  input  logic             take_i,
  output logic [DataW-1:0] pattern_o [NUM_DIGITS]
);

  logic             valid_q;
  logic [DataW-1:0] pattern_q [NUM_DIGITS];
  logic [DataW-1:0] pattern_d [NUM_DIGITS];
  logic             ended     [NUM_DIGITS];
  logic             load;

  // A position is blank once any position up to and including it ended.
  always_comb begin
    for (int p = 0; p < NUM_DIGITS; p++) begin
      if (p == 0) begin
        ended[p] = is_end_i[p];
      end else begin
        ended[p] = ended[p-1] | is_end_i[p];
      end
      pattern_d[p] = ended[p] ? BlankGlyph : glyph_i[p];
    end
  end

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pattern_q <= pattern_d;
    end
  end

  assign valid_o   = valid_q;
  assign pattern_o = pattern_q;

endmodule

// ===== rtl/t2s_serializer.sv =====
// Frame serializer: sends the decode-mode frame and then one frame per
// digit, from the highest digit register down. Depends on t2s_pkg.
module t2s_serializer import t2s_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NumDigitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             take_o,
  input  logic [DataW-1:0] pattern_i [NUM_DIGITS],
  t2s_frame_if.source      out_o
);

  localparam logic [AddrW-1:0] TopDigitReg = AddrW'(NUM_DIGITS);

  logic             active_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] buf_q [NUM_DIGITS];
  logic             is_decode;
  logic             is_last;
  logic             advance;

  assign is_decode = (addr_q == DecodeModeReg);
  assign is_last   = (addr_q == FirstDigitReg);
  assign advance   = active_q && out_o.ready;
  // A new message loads when the run is over or its last frame leaves now.
  assign take_o    = valid_i && (!active_q || (advance && is_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      addr_q   <= DecodeModeReg;
    end else if (take_o) begin
      active_q <= 1'b1;
      addr_q   <= DecodeModeReg;
    end else if (advance) begin
      if (is_last) begin
        active_q <= 1'b0;
      end else if (is_decode) begin
        addr_q <= TopDigitReg;
      end else begin
        addr_q <= addr_q - AddrW'(1);
      end
    end
  end

  // The pattern of the current digit always sits at the head of the buffer.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      buf_q <= pattern_i;
    end else if (advance && !is_decode) begin
      for (int i = 0; i < NUM_DIGITS - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
      buf_q[NUM_DIGITS-1] <= BlankGlyph;
    end
  end

  assign out_o.valid       = active_q;
  assign out_o.reg_address = addr_q;
  assign out_o.reg_data    = is_decode ? DecodeModeOff : buf_q[0];
  assign out_o.last_frame  = is_last;

endmodule

// ===== rtl/text_to_segment_frame_sequencer.sv =====
// The first frame of a message leaves once the message has passed the merge
// register and has then been loaded into the frame serializer.
// The serializer sends NUM_DIGITS + 1 frames per message, one frame per cycle
// while out_o.ready is high, and the merge register takes the next message
// while the current run is still going out.
// Reset (asynchronous, active low) empties both stages; no memory to clear.
module text_to_segment_frame_sequencer import t2s_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NumDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  t2s_char_if.sink    in_i,
  t2s_frame_if.source out_o
);

  logic [CharW-1:0] chars    [CharFields];
  logic [DataW-1:0] glyph    [NUM_DIGITS];
  logic             is_end   [NUM_DIGITS];
  logic [DataW-1:0] pattern  [NUM_DIGITS];
  logic             s1_valid;
  logic             s1_take;

  assign chars[0] = in_i.char_0;
  assign chars[1] = in_i.char_1;
  assign chars[2] = in_i.char_2;
  assign chars[3] = in_i.char_3;
  assign chars[4] = in_i.char_4;

  for (genvar p = 0; p < NUM_DIGITS; p++) begin : g_lane
    logic [CharW-1:0] lane_char;
    // Digits beyond the message fields see an end-of-message code.
    if (p < CharFields) begin : g_field
      assign lane_char = chars[p];
    end else begin : g_pad
      assign lane_char = EndOfMessage;
    end
    t2s_lane u_lane (
      .char_i   (lane_char),
      .glyph_o  (glyph[p]),
      .is_end_o (is_end[p])
    );
  end

  t2s_merge #(.NUM_DIGITS(NUM_DIGITS)) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .glyph_i    (glyph),
    .is_end_i   (is_end),
    .valid_o    (s1_valid),
    .take_i     (s1_take),
    .pattern_o  (pattern)
  );

  t2s_serializer #(.NUM_DIGITS(NUM_DIGITS)) u_serializer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .take_o    (s1_take),
    .pattern_i (pattern),
    .out_o     (out_o)
  );

endmodule

// ===== rtl/t2s_checker.sv =====
// Port-level checks on the frame sequencer's output channel, attached to
// the top level by a bind statement. Depends on t2s_pkg.
module t2s_checker import t2s_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NumDigitsDefault
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [AddrW-1:0] out_addr_i,
  input logic [DataW-1:0] out_data_i,
  input logic             out_last_i
);

  // A stalled item keeps its frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_addr_i)
      && $stable(out_data_i) && $stable(out_last_i))
    else $error("frame changed while stalled");

  // The decode-mode frame writes zero and never ends a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_addr_i == DecodeModeReg |-> out_data_i == DecodeModeOff && !out_last_i)
    else $error("bad decode-mode frame");

  // A run ends exactly at the lowest digit register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_last_i == (out_addr_i == FirstDigitReg))
    else $error("last frame flag out of place");

  // Digit addresses stay within the configured digit count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_addr_i != DecodeModeReg |->
      out_addr_i != '0 && out_addr_i <= AddrW'(NUM_DIGITS))
    else $error("digit address out of range");

  // A run goes out without gaps once started.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside a run of frames");

endmodule

bind text_to_segment_frame_sequencer t2s_checker #(.NUM_DIGITS(NUM_DIGITS)) u_t2s_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_addr_i  (out_o.reg_address),
  .out_data_i  (out_o.reg_data),
  .out_last_i  (out_o.last_frame)
);

// ===== tb/text_to_segment_frame_checker.sv =====
// Scoreboard for the text-to-segment frame sequencer: watches the message and
// frame channels, predicts each run of register frames and compares them.
// Depends on t2s_pkg, t2s_char_if and t2s_frame_if.
`timescale 1ns / 100ps

module text_to_segment_frame_checker import t2s_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NumDigitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  t2s_char_if  chars_i,
  t2s_frame_if frames_i,
  output int   mismatches_o,
  output int   frames_pending_o
);

  typedef logic [CharFields-1:0][CharW-1:0] message_t;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic [DataW-1:0] data;
    logic             last;
  } frame_t;

  frame_t expected_frames_q[$];
  int     frames_seen    = 0;
  int     mismatch_count = 0;
  int     pending_count  = 0;

  assign mismatches_o     = mismatch_count;
  assign frames_pending_o = pending_count;

  // Segment pattern (bit 6 = a ... bit 0 = g) of one character code.
  function automatic logic [DataW-1:0] segments_for(input logic [CharW-1:0] code);
    logic [DataW-1:0] seg;
    case (code)
      "0", "O": seg = 8'h7e;
      "1", "I": seg = 8'h30;
      "2":      seg = 8'h6d;
      "3":      seg = 8'h79;
      "4":      seg = 8'h33;
      "5", "S": seg = 8'h5b;
      "6":      seg = 8'h5f;
      "7":      seg = 8'h70;
      "8":      seg = 8'h7f;
      "9":      seg = 8'h7b;
      "A":      seg = 8'h77;
      "C":      seg = 8'h4e;
      "D":      seg = 8'h3d;
      "E":      seg = 8'h4f;
      "F":      seg = 8'h47;
      "H":      seg = 8'h37;
      "L":      seg = 8'h0e;
      "N":      seg = 8'h15;
      "P":      seg = 8'h67;
      "R":      seg = 8'h05;
      "T":      seg = 8'h0f;
      "U":      seg = 8'h1c;
      "V":      seg = 8'h3e;
      "Y":      seg = 8'h3b;
      "-":      seg = 8'h01;
      default:  seg = BlankGlyph;
    endcase
    return seg;
  endfunction

  // One decode-mode frame, then the digit registers from the highest down.
  // Everything from the first terminator on is shown blank.
  function automatic void predict_frames(input message_t msg);
    logic             ended;
    logic [DataW-1:0] seg;
    int               pos;
    ended = 1'b0;
    expected_frames_q.push_back('{DecodeModeReg, DecodeModeOff, NUM_DIGITS == 0});
    for (pos = 0; pos < NUM_DIGITS; pos++) begin
      seg = BlankGlyph;
      if (pos < CharFields && !ended) begin
        if (msg[pos] == EndOfMessage) begin
          ended = 1'b1;
        end else begin
          seg = segments_for(msg[pos]);
        end
      end
      expected_frames_q.push_back('{AddrW'(NUM_DIGITS - pos), seg, pos == NUM_DIGITS - 1});
    end
  endfunction

  task automatic report_mismatch(input string text);
    $display("[%0t] frame %0d: %s", $realtime, frames_seen, text);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t got;
    frame_t want;
    if (!rst_ni) begin
      expected_frames_q.delete();
      pending_count = 0;
    end else begin
      if (frames_i.valid && frames_i.ready) begin
        got = '{frames_i.reg_address, frames_i.reg_data, frames_i.last_frame};
        if (expected_frames_q.size() == 0) begin
          report_mismatch($sformatf("unexpected frame addr 0x%0h data 0x%0h last %0b",
                                    got.address, got.data, got.last));
        end else begin
          want = expected_frames_q.pop_front();
          if (got.address !== want.address)
            report_mismatch($sformatf("reg_address got 0x%0h, expected 0x%0h",
                                      got.address, want.address));
          if (got.data !== want.data)
            report_mismatch($sformatf("reg_data got 0x%0h, expected 0x%0h",
                                      got.data, want.data));
          if (got.last !== want.last)
            report_mismatch($sformatf("last_frame got %0b, expected %0b",
                                      got.last, want.last));
        end
        frames_seen++;
      end
      if (chars_i.valid && chars_i.ready) begin
        predict_frames({chars_i.char_4, chars_i.char_3, chars_i.char_2,
                        chars_i.char_1, chars_i.char_0});
      end
      pending_count = expected_frames_q.size();
    end
  end

endmodule

// ===== tb/tb_text_to_segment_frame_sequencer.sv =====
// Top of the sequencer testbench: clock, reset, message stimulus and frame
// back-pressure. Depends on t2s_pkg, both channel interfaces and the checker.
`timescale 1ns / 100ps

module tb_text_to_segment_frame_sequencer;
  import t2s_pkg::*;

  localparam int unsigned NumDigits   = NumDigitsDefault;
  localparam int          RandomItems = 310;
  localparam int          IdlePercent = 17;
  localparam int          CycleLimit  = 200000;
  localparam int          HoldOffLen  = 200;
  localparam string       GlyphChars  = "HICNDSLPUAFYE-RTOV0123456789";

  typedef logic [CharFields-1:0][CharW-1:0] message_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatches;
  int   frames_pending;
  int   cycle_count   = 0;
  bit   steady_phase  = 1'b0;
  bit   holdoff_armed = 1'b0;

  t2s_char_if  chars_if ();
  t2s_frame_if frames_if ();

  text_to_segment_frame_sequencer #(.NUM_DIGITS(NumDigits)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (chars_if),
    .out_o (frames_if)
  );

  text_to_segment_frame_checker #(.NUM_DIGITS(NumDigits)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .chars_i         (chars_if),
    .frames_i        (frames_if),
    .mismatches_o    (mismatches),
    .frames_pending_o(frames_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("text_to_segment_frame_sequencer regression: fail");
      $finish;
    end
  end

  function automatic message_t make_msg(input logic [CharW-1:0] c0, input logic [CharW-1:0] c1,
                                        input logic [CharW-1:0] c2, input logic [CharW-1:0] c3,
                                        input logic [CharW-1:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  function automatic logic [CharW-1:0] any_glyph_char();
    return GlyphChars[$urandom_range(GlyphChars.len() - 1)];
  endfunction

  // Mostly well-formed text with a terminator, the rest raw or mixed codes.
  function automatic message_t random_message();
    message_t msg;
    int       kind;
    int       text_len;
    int       pos;
    kind     = $urandom_range(99);
    text_len = $urandom_range(CharFields);
    for (pos = 0; pos < CharFields; pos++) begin
      if (kind < 55) begin
        if (pos < text_len)       msg[pos] = any_glyph_char();
        else if (pos == text_len) msg[pos] = EndOfMessage;
        else                      msg[pos] = CharW'($urandom_range(255));
      end else if (kind < 80) begin
        msg[pos] = CharW'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0:       msg[pos] = any_glyph_char();
          1:       msg[pos] = EndOfMessage;
          2:       msg[pos] = CharW'($urandom_range(255));
          default: msg[pos] = CharW'("a" + $urandom_range(25));
        endcase
      end
    end
    return msg;
  endfunction

  // Entered and left just after a falling edge; valid stays high on exit so
  // that back-to-back messages need no extra assignment.
  task automatic send_message(input message_t msg);
    while (!steady_phase && $urandom_range(99) < IdlePercent) begin
      chars_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    chars_if.valid  <= 1'b1;
    chars_if.char_0 <= msg[0];
    chars_if.char_1 <= msg[1];
    chars_if.char_2 <= msg[2];
    chars_if.char_3 <= msg[3];
    chars_if.char_4 <= msg[4];
    do @(posedge clk_i); while (!chars_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_for_all_frames();
    chars_if.valid <= 1'b0;
    @(negedge clk_i);
    while (frames_pending != 0) @(negedge clk_i);
  endtask

  // Frame receiver with random stalls, one long hold-off and a steady stretch.
  initial begin
    int  holdoff_left;
    bit  holdoff_taken;
    holdoff_left    = 0;
    holdoff_taken   = 1'b0;
    frames_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (holdoff_armed && !holdoff_taken) begin
        holdoff_taken = 1'b1;
        holdoff_left  = HoldOffLen;
      end
      if (holdoff_left > 0) begin
        frames_if.ready <= 1'b0;
        holdoff_left--;
      end else if (steady_phase) begin
        frames_if.ready <= 1'b1;
      end else begin
        frames_if.ready <= ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  initial begin
    message_t directed_msgs[$];
    int       idx;
    chars_if.valid  = 1'b0;
    chars_if.char_0 = '0;
    chars_if.char_1 = '0;
    chars_if.char_2 = '0;
    chars_if.char_3 = '0;
    chars_if.char_4 = '0;

    // Whole table, terminator at either end and in the middle, unknown codes,
    // alternating bit patterns and the field extremes.
    directed_msgs.push_back(make_msg("H", "I", "C", "N", "D"));
    directed_msgs.push_back(make_msg("S", "L", "P", "U", "A"));
    directed_msgs.push_back(make_msg("F", "Y", "E", "-", "R"));
    directed_msgs.push_back(make_msg("T", "O", "V", "0", "1"));
    directed_msgs.push_back(make_msg("2", "3", "4", "5", "6"));
    directed_msgs.push_back(make_msg("7", "8", "9", "-", "H"));
    directed_msgs.push_back(make_msg(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    directed_msgs.push_back(make_msg(8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    directed_msgs.push_back(make_msg(EndOfMessage, "A", "C", "D", "E"));
    directed_msgs.push_back(make_msg("A", "C", EndOfMessage, "D", "E"));
    directed_msgs.push_back(make_msg("A", "C", "D", "E", EndOfMessage));
    directed_msgs.push_back(make_msg("E", EndOfMessage, "8", EndOfMessage, "8"));
    directed_msgs.push_back(make_msg("a", 8'h80, 8'h7f, 8'h01, "z"));
    directed_msgs.push_back(make_msg("B", "G", "J", "K", "M"));
    directed_msgs.push_back(make_msg(8'haa, 8'h55, 8'haa, 8'h55, 8'haa));
    directed_msgs.push_back(make_msg(8'h55, 8'haa, 8'h55, 8'haa, 8'h55));
    directed_msgs.push_back(make_msg("8", "8", "8", "8", "8"));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_msgs[i]) send_message(directed_msgs[i]);

    for (idx = 0; idx < RandomItems; idx++) begin
      // The receiver stalls for a long stretch while messages keep coming.
      if (idx == 60) holdoff_armed = 1'b1;
      steady_phase = (idx >= 120 && idx < 200);
      // Let the sequencer drain completely before carrying on.
      if (idx == 240) wait_for_all_frames();
      send_message(random_message());
    end

    wait_for_all_frames();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && frames_pending == 0) begin
      $display("text_to_segment_frame_sequencer regression: pass");
    end else begin
      $display("text_to_segment_frame_sequencer regression: fail");
    end
    $finish;
  end

endmodule
